// File: rtl/core/tccw_pkg.sv
// tccw_pkg: shared types and constants for the text console character writer.
// Holds the transaction structs, character codes and controller state encoding.
// No dependencies.
`default_nettype none

package tccw_pkg;

    localparam logic       OP_PUT  = 1'b0;
    localparam logic       OP_READ = 1'b1;

    localparam logic [7:0]  CODE_NEWLINE   = 8'h0A;
    localparam logic [7:0]  CODE_BACKSPACE = 8'h08;
    localparam logic [7:0]  CODE_SPACE     = 8'h20;
    localparam logic [15:0] RESET_CELL     = 16'h0F20;
    localparam logic [7:0]  ATTR_RESET     = 8'h0F;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  char_code;
        logic [10:0] cell_address;
    } request_t;

    typedef struct packed {
        logic [15:0] cell_value;
        logic [6:0]  cursor_column;
        logic [4:0]  cursor_row;
        logic        scrolled;
    } result_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_COPY,
        ST_BLANK
    } state_t;

endpackage

`default_nettype wire

// File: rtl/core/text_console_char_writer_unit.sv
// text_console_char_writer_unit: character-cell screen store, cursor and scroll sequencer.
// Depends on tccw_pkg. Put: result strobed in the cycle after the transaction; a read passes ST_READ first.
// A put that scrolls copies the screen through the single-port-read memory one cell a cycle,
// then blanks the bottom row before the result. One transaction at a time (busy).
// Reset clears the store to RESET_CELL in ST_CLEAR, busy meanwhile.
// The receiver cannot stall: done is high for exactly one cycle per transaction.
`default_nettype none

module text_console_char_writer_unit #(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 25
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire tccw_pkg::request_t request,
    output logic                    done,
    output tccw_pkg::result_t       result,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [7:0]         cfg_data
);

    localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;
    localparam int CELL_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = $clog2(SCREEN_COLUMNS);
    localparam int ROW_W      = $clog2(SCREEN_ROWS);

    logic [15:0] screen_mem [CELL_COUNT];
    logic [15:0] rdata_reg;

    tccw_pkg::state_t state_reg, state_next;

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [CELL_W-1:0] cnt_reg, cnt_next;
    logic [7:0]        attr_reg;
    logic [15:0]       value_reg, value_next;
    logic              scrolled_reg, scrolled_next;
    logic              done_reg, done_next;
    logic              inrange_reg, inrange_next;

    logic              mem_we, mem_re;
    logic [CELL_W-1:0] mem_waddr, mem_raddr;
    logic [15:0]       mem_wdata;

    logic [COL_W-1:0]  bs_col, wr_col;
    logic [ROW_W-1:0]  bs_row, wr_row;
    logic [COL_W:0]    nc;
    logic [ROW_W:0]    nr;
    logic              put_scroll, put_we;
    logic [15:0]       put_data, blank;
    logic [CELL_W-1:0] put_addr, rd_addr;
    logic [CELL_W+10:0] addr_ext;
    logic              addr_ok, accept;
    logic [COL_W+7:0]  col_wide;
    logic [ROW_W+5:0]  row_wide;

    assign accept    = start && !busy;
    assign busy      = (state_reg != tccw_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign blank     = {attr_reg, tccw_pkg::CODE_SPACE};
    assign addr_ext  = {{CELL_W{1'b0}}, request.cell_address};
    assign rd_addr   = addr_ext[CELL_W-1:0];
    assign addr_ok   = (32'(request.cell_address) < CELL_COUNT);

    assign col_wide  = {8'b0, col_reg};
    assign row_wide  = {6'b0, row_reg};
    assign done      = done_reg;
    assign result.cell_value    = value_reg;
    assign result.cursor_column = col_wide[6:0];
    assign result.cursor_row    = row_wide[4:0];
    assign result.scrolled      = scrolled_reg;

    // cursor update for a put
    always_comb
    begin
        bs_col = col_reg;
        bs_row = row_reg;
        if (col_reg != '0)
        begin
            bs_col = col_reg - 1'b1;
        end
        else if (row_reg != '0)
        begin
            bs_row = row_reg - 1'b1;
            bs_col = COL_W'(SCREEN_COLUMNS - 1);
        end
        wr_col   = col_reg;
        wr_row   = row_reg;
        nc       = {1'b0, col_reg} + 1'b1;
        nr       = {1'b0, row_reg};
        put_we   = 1'b1;
        put_data = {attr_reg, request.char_code};
        case (request.char_code)
            tccw_pkg::CODE_NEWLINE:
            begin
                put_we = 1'b0;
                nc     = '0;
                nr     = {1'b0, row_reg} + 1'b1;
            end
            tccw_pkg::CODE_BACKSPACE:
            begin
                wr_col   = bs_col;
                wr_row   = bs_row;
                nc       = {1'b0, bs_col};
                nr       = {1'b0, bs_row};
                put_data = blank;
            end
            default:
            begin
            end
        endcase
        if (nc >= (COL_W+1)'(SCREEN_COLUMNS))
        begin
            nc = '0;
            nr = nr + 1'b1;
        end
        put_scroll = (nr >= (ROW_W+1)'(SCREEN_ROWS));
        if (put_scroll)
        begin
            nr = (ROW_W+1)'(SCREEN_ROWS - 1);
        end
        put_addr = CELL_W'(32'(wr_row) * SCREEN_COLUMNS + 32'(wr_col));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tccw_pkg::ST_CLEAR:
            begin
                if (cnt_reg == CELL_W'(CELL_COUNT - 1))
                begin
                    state_next = tccw_pkg::ST_IDLE;
                end
            end
            tccw_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (request.opcode == tccw_pkg::OP_READ)
                    begin
                        state_next = tccw_pkg::ST_READ;
                    end
                    else if (put_scroll)
                    begin
                        state_next = tccw_pkg::ST_COPY;
                    end
                end
            end
            tccw_pkg::ST_READ:
            begin
                state_next = tccw_pkg::ST_IDLE;
            end
            tccw_pkg::ST_COPY:
            begin
                if (cnt_reg == CELL_W'(CELL_COUNT - SCREEN_COLUMNS - 1))
                begin
                    state_next = tccw_pkg::ST_BLANK;
                end
            end
            tccw_pkg::ST_BLANK:
            begin
                if (cnt_reg == CELL_W'(CELL_COUNT - 1))
                begin
                    state_next = tccw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tccw_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        mem_we        = 1'b0;
        mem_waddr     = cnt_reg;
        mem_wdata     = put_data;
        mem_re        = 1'b0;
        mem_raddr     = rd_addr;
        col_next      = col_reg;
        row_next      = row_reg;
        cnt_next      = cnt_reg;
        value_next    = value_reg;
        scrolled_next = scrolled_reg;
        done_next     = 1'b0;
        inrange_next  = inrange_reg;
        case (state_reg)
            tccw_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = tccw_pkg::RESET_CELL;
                cnt_next  = cnt_reg + 1'b1;
            end
            tccw_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (request.opcode == tccw_pkg::OP_READ)
                    begin
                        mem_re       = addr_ok;
                        inrange_next = addr_ok;
                    end
                    else
                    begin
                        mem_we    = put_we;
                        mem_waddr = put_addr;
                        col_next  = nc[COL_W-1:0];
                        row_next  = nr[ROW_W-1:0];
                        if (put_scroll)
                        begin
                            mem_re    = 1'b1;
                            mem_raddr = CELL_W'(SCREEN_COLUMNS);
                            cnt_next  = '0;
                        end
                        else
                        begin
                            done_next     = 1'b1;
                            value_next    = '0;
                            scrolled_next = 1'b0;
                        end
                    end
                end
            end
            tccw_pkg::ST_READ:
            begin
                done_next     = 1'b1;
                value_next    = inrange_reg ? rdata_reg : 16'h0000;
                scrolled_next = 1'b0;
            end
            tccw_pkg::ST_COPY:
            begin
                mem_we    = 1'b1;
                mem_wdata = rdata_reg;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg != CELL_W'(CELL_COUNT - SCREEN_COLUMNS - 1))
                begin
                    mem_re    = 1'b1;
                    mem_raddr = cnt_reg + CELL_W'(SCREEN_COLUMNS + 1);
                end
            end
            tccw_pkg::ST_BLANK:
            begin
                mem_we    = 1'b1;
                mem_wdata = blank;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CELL_W'(CELL_COUNT - 1))
                begin
                    done_next     = 1'b1;
                    value_next    = '0;
                    scrolled_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tccw_pkg::ST_CLEAR;
            col_reg   <= '0;
            row_reg   <= '0;
            cnt_reg   <= '0;
            attr_reg  <= tccw_pkg::ATTR_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                attr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        scrolled_reg <= scrolled_next;
        inrange_reg  <= inrange_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rdata_reg <= screen_mem[mem_raddr];
        end
    end

endmodule

`default_nettype wire

// File: tb/text_console_char_writer_unit_tb.sv
// Self-checking testbench for text_console_char_writer_unit: text puts, newline, backspace,
// cell reads and scrolling, checked against an in-bench screen and cursor model.
// Depends on tccw_pkg and the unit itself; the attribute is written between drained phases.
module text_console_char_writer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS = 80;
    localparam int ROWS = 25;
    localparam int CELLS = COLS * ROWS;
    localparam int QUIET_LIMIT = 20000;
    localparam int SETTLE_CYCLES = CELLS + 100;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    tccw_pkg::request_t request = '0;
    logic               done;
    tccw_pkg::result_t  result;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [7:0]         cfg_data = '0;

    // model state
    logic [15:0] screen_model [0:CELLS-1];
    int          col_model = 0;
    int          row_model = 0;
    logic [7:0]  attr_model = tccw_pkg::ATTR_RESET;

    tccw_pkg::request_t console_requests[$];
    tccw_pkg::result_t  due_reports[$];
    int       sender_idle_pct = 0;
    int       mismatches = 0;
    int       reports_seen = 0;
    int       quiet_cycles = 0;

    text_console_char_writer_unit #(
        .SCREEN_COLUMNS(COLS),
        .SCREEN_ROWS   (ROWS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .done     (done),
        .result   (result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        for (int i = 0; i < CELLS; i++)
            screen_model[i] = tccw_pkg::RESET_CELL;
    end

    function automatic tccw_pkg::result_t console_advance(tccw_pkg::request_t req);
        tccw_pkg::result_t r;
        logic [15:0]       blank;
        r = '0;
        blank = {attr_model, tccw_pkg::CODE_SPACE};
        if (req.opcode == tccw_pkg::OP_READ)
        begin
            if (req.cell_address < CELLS)
                r.cell_value = screen_model[req.cell_address];
        end
        else
        begin
            if (req.char_code == tccw_pkg::CODE_NEWLINE)
            begin
                col_model = 0;
                row_model++;
            end
            else if (req.char_code == tccw_pkg::CODE_BACKSPACE)
            begin
                if (col_model > 0)
                    col_model--;
                else if (row_model > 0)
                begin
                    row_model--;
                    col_model = COLS - 1;
                end
                screen_model[row_model * COLS + col_model] = blank;
            end
            else
            begin
                screen_model[row_model * COLS + col_model] = {attr_model, req.char_code};
                col_model++;
            end
            if (col_model >= COLS)
            begin
                col_model = 0;
                row_model++;
            end
            if (row_model >= ROWS)
            begin
                for (int i = 0; i < CELLS - COLS; i++)
                    screen_model[i] = screen_model[i + COLS];
                for (int i = CELLS - COLS; i < CELLS; i++)
                    screen_model[i] = blank;
                row_model = ROWS - 1;
                r.scrolled = 1'b1;
            end
        end
        r.cursor_column = col_model[6:0];
        r.cursor_row = row_model[4:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        if (mismatches < 40)
            $display("[%0t] result %0d: %s expected %0h got %0h",
                     $time, reports_seen, what, want, got);
        mismatches++;
    endtask

    // driver: one transaction in flight, start held until accepted
    always @(posedge clk or negedge rst_n)
    begin : sender
        logic free;
        if (!rst_n)
        begin
            start <= 1'b0;
            request <= '0;
        end
        else
        begin
            free = !start || !busy;
            if (start && !busy)
                due_reports.push_back(console_advance(request));
            if (free)
            begin
                if (console_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    start <= 1'b1;
                    request <= console_requests.pop_front();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor and watchdog
    always @(posedge clk)
    begin : receiver
        tccw_pkg::result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (due_reports.size() == 0)
                    report_mismatch("result with none due", '0, result);
                else
                begin
                    want = due_reports.pop_front();
                    if (result.cell_value !== want.cell_value)
                        report_mismatch("cell_value", want.cell_value, result.cell_value);
                    if (result.cursor_column !== want.cursor_column)
                        report_mismatch("cursor_column", want.cursor_column,
                                        result.cursor_column);
                    if (result.cursor_row !== want.cursor_row)
                        report_mismatch("cursor_row", want.cursor_row, result.cursor_row);
                    if (result.scrolled !== want.scrolled)
                        report_mismatch("scrolled", want.scrolled, result.scrolled);
                end
                reports_seen++;
            end
            if (done || (start && !busy) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
                $display("Verification failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic tccw_pkg::request_t make_request(logic op, logic [7:0] ch,
                                                        logic [10:0] addr);
        tccw_pkg::request_t r;
        r.opcode = op;
        r.char_code = ch;
        r.cell_address = addr;
        return r;
    endfunction

    function automatic logic [7:0] pick_glyph();
        logic [7:0] g;
        do
            g = 8'($urandom_range(255));
        while (g == tccw_pkg::CODE_NEWLINE || g == tccw_pkg::CODE_BACKSPACE);
        return g;
    endfunction

    function automatic logic [10:0] pick_address();
        int k;
        k = $urandom_range(9);
        if (k == 0)
            return 11'($urandom_range(2047, CELLS));
        else if (k == 1)
            return 11'($urandom_range(CELLS - 1, CELLS - COLS));
        else if (k == 2)
            return 11'($urandom_range(2 * COLS - 1, 0));
        return 11'($urandom_range(CELLS - 1, 0));
    endfunction

    task automatic put(logic [7:0] ch);
        console_requests.push_back(make_request(tccw_pkg::OP_PUT, ch, 11'($urandom)));
    endtask

    task automatic read(logic [10:0] addr);
        console_requests.push_back(make_request(tccw_pkg::OP_READ, 8'($urandom), addr));
    endtask

    // text runs, newline and backspace bursts, reads, and some raw noise
    task automatic queue_random(int count);
        int added;
        int burst;
        int k;
        added = 0;
        while (added < count)
        begin
            k = $urandom_range(99);
            if (k < 30)
                burst = $urandom_range(100, 1);
            else if (k < 50)
                burst = $urandom_range(4, 1);
            else if (k < 60)
                burst = $urandom_range(6, 1);
            else
                burst = 1;
            for (int i = 0; i < burst && added < count; i++)
            begin
                if (k < 30)
                    put(pick_glyph());
                else if (k < 50)
                    put(tccw_pkg::CODE_NEWLINE);
                else if (k < 60)
                    put(tccw_pkg::CODE_BACKSPACE);
                else if (k < 90)
                    read(pick_address());
                else
                    console_requests.push_back(tccw_pkg::request_t'(20'($urandom)));
                added++;
            end
        end
    endtask

    task automatic write_attribute(logic [7:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        attr_model = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (console_requests.size() != 0 || start || due_reports.size() != 0 || busy);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        sender_idle_pct = 19;
        write_attribute(8'hFF);
        read(11'd0);
        read(11'(CELLS - 1));
        read(11'(CELLS));
        read(11'h7FF);
        put(tccw_pkg::CODE_BACKSPACE);
        read(11'd0);
        put(8'h00);
        put(8'hFF);
        put(8'h41);
        put(tccw_pkg::CODE_BACKSPACE);
        read(11'd2);
        put(tccw_pkg::CODE_NEWLINE);
        put(tccw_pkg::CODE_BACKSPACE);
        read(11'(COLS - 1));
        put(8'h7F);
        read(11'(COLS - 1));
        put(8'h09);
        put(8'h0B);
        read(11'(COLS));
        drain();

        write_attribute(8'($urandom_range(254, 1)));
        queue_random(317);
        drain();

        sender_idle_pct = 53;
        write_attribute(8'h00);
        queue_random(317);
        drain();

        sender_idle_pct = 0;
        write_attribute(8'($urandom_range(255)));
        queue_random(316);
        drain();

        repeat (SETTLE_CYCLES) @(posedge clk);
        while (due_reports.size() != 0)
            report_mismatch("result never arrived", due_reports.pop_front(), '0);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
